/* rtl/nps_pkg.sv */
// Shared constants and types for the next-permutation step block.
`timescale 1ns / 1ps
package nps_pkg;

	localparam int NUM_ELEMS  = 8;
	localparam int ELEM_WIDTH = 4;
	localparam int IDX_W      = $clog2(NUM_ELEMS);
	localparam int LEN_W      = 4;
	// Wide enough for an index sum such as lo + len
	localparam int SUM_W      = LEN_W + 1;

	typedef logic [ELEM_WIDTH-1:0] elem_t;
	typedef logic [LEN_W-1:0]      len_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [SUM_W-1:0]      sum_t;
	typedef logic [NUM_ELEMS-1:0]  hit_vec_t;

	// Result of a merge over the lane hits
	typedef struct packed {
		logic any;
		idx_t idx;
	} pick_t;

endpackage

/* rtl/nps_lane.sv */
// One compare lane: strict unsigned less-than, gated by an enable.
`timescale 1ns / 1ps
module nps_lane (
	input  nps_pkg::elem_t a,
	input  nps_pkg::elem_t b,
	input  logic           en,
	output logic           hit
);

	// Flag a < b only where the lane takes part
	assign hit = en && (a < b);

endmodule

/* rtl/nps_merge.sv */
// Merge stage: picks the highest lane that reports a hit.
`timescale 1ns / 1ps
module nps_merge (
	input  nps_pkg::hit_vec_t hits,
	output nps_pkg::pick_t    pick
);

	// Scan upward so the rightmost hit wins
	always_comb begin
		pick.any = 1'b0;
		pick.idx = '0;
		for (int k = 0; k < nps_pkg::NUM_ELEMS; k++) begin
			if (hits[k]) begin
				pick.any = 1'b1;
				pick.idx = nps_pkg::idx_t'(k);
			end
		end
	end

endmodule

/* rtl/next_permutation_step_top.sv */
// Top level: next lexicographic permutation of a multiset, three-stage pipeline.
// Stages: ascent lanes, pivot merge and greater lanes, output mux. An accepted request
//   moves through the stage 1, stage 2 and output registers; done rises with the result.
// Throughput: one request per cycle; busy stays low, results cannot be stalled.
// Reset: arst_n clears the stage valids and done at once; payload is not reset.
`timescale 1ns / 1ps
module next_permutation_step_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  nps_pkg::elem_t       elem_0,
	input  nps_pkg::elem_t       elem_1,
	input  nps_pkg::elem_t       elem_2,
	input  nps_pkg::elem_t       elem_3,
	input  nps_pkg::elem_t       elem_4,
	input  nps_pkg::elem_t       elem_5,
	input  nps_pkg::elem_t       elem_6,
	input  nps_pkg::elem_t       elem_7,
	input  nps_pkg::len_t        used_length,
	output logic                 done,
	output nps_pkg::elem_t       out_0,
	output nps_pkg::elem_t       out_1,
	output nps_pkg::elem_t       out_2,
	output nps_pkg::elem_t       out_3,
	output nps_pkg::elem_t       out_4,
	output nps_pkg::elem_t       out_5,
	output nps_pkg::elem_t       out_6,
	output nps_pkg::elem_t       out_7,
	output logic                 has_next
);

	localparam int N = nps_pkg::NUM_ELEMS;

	nps_pkg::elem_t    elems_in [N];
	nps_pkg::len_t     len_in;
	nps_pkg::hit_vec_t asc_in;

	nps_pkg::elem_t    elems_s1 [N];
	nps_pkg::len_t     len_s1;
	nps_pkg::hit_vec_t asc_s1;
	logic              vld_s1;

	nps_pkg::pick_t    piv;
	nps_pkg::elem_t    piv_val;
	nps_pkg::hit_vec_t gt_hits;

	nps_pkg::elem_t    elems_s2 [N];
	nps_pkg::len_t     len_s2;
	nps_pkg::pick_t    piv_s2;
	nps_pkg::hit_vec_t gt_s2;
	logic              vld_s2;

	nps_pkg::pick_t    swp;
	nps_pkg::sum_t     lo;
	nps_pkg::elem_t    res [N];

	nps_pkg::elem_t    out_q [N];
	logic              has_next_q;
	logic              done_q;

	// Every cycle is open for a new request
	assign busy = 1'b0;

	assign elems_in[0] = elem_0;
	assign elems_in[1] = elem_1;
	assign elems_in[2] = elem_2;
	assign elems_in[3] = elem_3;
	assign elems_in[4] = elem_4;
	assign elems_in[5] = elem_5;
	assign elems_in[6] = elem_6;
	assign elems_in[7] = elem_7;

	// Saturate the length to the array size
	assign len_in = (used_length > nps_pkg::len_t'(N)) ? nps_pkg::len_t'(N) : used_length;

	// Ascent lanes: position k rises into k+1 within the used part
	assign asc_in[N-1] = 1'b0;
	for (genvar k = 0; k < N - 1; k++) begin : g_asc
		nps_lane u_lane (
			.a   (elems_in[k]),
			.b   (elems_in[k+1]),
			.en  (nps_pkg::sum_t'(k + 2) <= nps_pkg::sum_t'(len_in)),
			.hit (asc_in[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		elems_s1 <= elems_in;
		len_s1   <= len_in;
		asc_s1   <= asc_in;
	end

	// Merge the ascents into the pivot
	nps_merge u_piv (
		.hits (asc_s1),
		.pick (piv)
	);

	assign piv_val = elems_s1[piv.idx];

	// Greater lanes: later used elements above the pivot value
	for (genvar k = 0; k < N; k++) begin : g_gt
		nps_lane u_lane (
			.a   (piv_val),
			.b   (elems_s1[k]),
			.en  (piv.any && (nps_pkg::idx_t'(k) > piv.idx) &&
			      (nps_pkg::len_t'(k) < len_s1)),
			.hit (gt_hits[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		elems_s2 <= elems_s1;
		len_s2   <= len_s1;
		piv_s2   <= piv;
		gt_s2    <= gt_hits;
	end

	// Merge the greater lanes into the swap partner
	nps_merge u_swp (
		.hits (gt_s2),
		.pick (swp)
	);

	// Reverse from just past the pivot, or from the start when there is none
	assign lo = piv_s2.any ? (nps_pkg::sum_t'(piv_s2.idx) + nps_pkg::sum_t'(1)) : '0;

	// Route each output position to its source element
	always_comb begin
		nps_pkg::sum_t src;
		for (int k = 0; k < N; k++) begin
			src = lo + nps_pkg::sum_t'(len_s2) - nps_pkg::sum_t'(1) - nps_pkg::sum_t'(k);
			res[k] = elems_s2[k];
			if (piv_s2.any && (nps_pkg::idx_t'(k) == piv_s2.idx)) begin
				res[k] = elems_s2[swp.idx];
			end else if ((nps_pkg::sum_t'(k) >= lo) &&
			             (nps_pkg::sum_t'(k) < nps_pkg::sum_t'(len_s2))) begin
				if (piv_s2.any && (src[nps_pkg::IDX_W-1:0] == swp.idx)) begin
					res[k] = elems_s2[piv_s2.idx];
				end else begin
					res[k] = elems_s2[src[nps_pkg::IDX_W-1:0]];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		out_q      <= res;
		has_next_q <= piv_s2.any;
	end

	assign done     = done_q;
	assign has_next = has_next_q;
	assign out_0    = out_q[0];
	assign out_1    = out_q[1];
	assign out_2    = out_q[2];
	assign out_3    = out_q[3];
	assign out_4    = out_q[4];
	assign out_5    = out_q[5];
	assign out_6    = out_q[6];
	assign out_7    = out_q[7];

endmodule

/* rtl/nps_checker.sv */
// Port-level checker for the next-permutation step block, bound to the top level.
`timescale 1ns / 1ps
module nps_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input nps_pkg::elem_t elem_0,
	input nps_pkg::elem_t elem_1,
	input nps_pkg::elem_t elem_2,
	input nps_pkg::elem_t elem_3,
	input nps_pkg::elem_t elem_4,
	input nps_pkg::elem_t elem_5,
	input nps_pkg::elem_t elem_6,
	input nps_pkg::elem_t elem_7,
	input nps_pkg::len_t  used_length,
	input logic           done,
	input nps_pkg::elem_t out_0,
	input nps_pkg::elem_t out_1,
	input nps_pkg::elem_t out_2,
	input nps_pkg::elem_t out_3,
	input nps_pkg::elem_t out_4,
	input nps_pkg::elem_t out_5,
	input nps_pkg::elem_t out_6,
	input nps_pkg::elem_t out_7,
	input logic           has_next
);

	// Every request yields a result
	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("request without a result");

	// No result without an earlier request
	a_done_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without a request");

	// A short length never reports a next permutation
	a_short_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(used_length, 3) < 4'd2)) |-> !has_next)
		else $error("has_next set for a short length");

	// The last element passes through when it lies past the length
	a_tail_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(used_length, 3) < 4'd8)) |-> (out_7 == $past(elem_7, 3)))
		else $error("element past the length changed");

endmodule

bind next_permutation_step_top nps_checker u_nps_checker (.*);
